// ===== hw/rtl/amd_pkg.sv =====
// Shared types, widths and mixing constants for the APU mixer and decimator.
package amd_pkg;

    // Phase accumulator format: unsigned, PHASE_FRAC_BITS fraction bits.
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = 25;
    localparam int STEP_W          = 24;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_RESET = 24'd2659740;

    // Channel level widths.
    localparam int LEVEL_W = 4;
    localparam int DELTA_W = 7;

    // Mixer arithmetic: Q8 coefficients that already include the scale of 20000.
    localparam int SUM_W = 23;
    localparam int ACC_W = 24;
    localparam int PCM_W = 15;
    localparam logic [SUM_W-1:0] K_PULSE    = 23'd38502;
    localparam logic [SUM_W-1:0] K_TRIANGLE = 23'd43571;
    localparam logic [SUM_W-1:0] K_NOISE    = 23'd25293;
    localparam logic [SUM_W-1:0] K_DELTA    = 23'd17152;
    localparam logic [ACC_W-1:0] K_OFFSET   = 24'd2560000;
    localparam logic [ACC_W-1:0] TRUNC_BIAS = 24'd255;
    localparam logic signed [PCM_W-1:0] PCM_MIN = -15'sd10000;
    localparam logic signed [PCM_W-1:0] PCM_MAX = 15'sd7055;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [LEVEL_W-1:0] pulse_one;
        logic [LEVEL_W-1:0] pulse_two;
        logic [LEVEL_W-1:0] triangle;
        logic [LEVEL_W-1:0] noise;
        logic [DELTA_W-1:0] delta;
    } t_levels;

    typedef struct packed {
        logic    valid;
        t_levels levels;
    } t_queue_item;

endpackage

// ===== hw/rtl/amd_front.sv =====
// Front part: accepts sound-chip cycles and picks the cycles that emit a sample.
module amd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [amd_pkg::LEVEL_W-1:0]   i_pulse_one_level,
    input  logic [amd_pkg::LEVEL_W-1:0]   i_pulse_two_level,
    input  logic [amd_pkg::LEVEL_W-1:0]   i_triangle_level,
    input  logic [amd_pkg::LEVEL_W-1:0]   i_noise_level,
    input  logic [amd_pkg::DELTA_W-1:0]   i_delta_level,
    input  logic                          i_cfg_wr_en,
    input  logic [amd_pkg::STEP_W-1:0]    i_cfg_wr_data,
    input  logic                          i_queue_full,
    output amd_pkg::t_queue_item          o_push
);

    logic [amd_pkg::STEP_W-1:0]  r_cycles_per_sample;
    logic [amd_pkg::PHASE_W-1:0] r_phase;
    logic [amd_pkg::PHASE_W-1:0] n_phase;
    logic [amd_pkg::PHASE_W-1:0] w_step;
    logic                        w_accept;
    logic                        w_emit;

    // A cycle is taken whenever the queue has room.
    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;

    // The sample instant falls in this cycle when less than one cycle remains.
    assign w_emit = r_phase < amd_pkg::PHASE_ONE;

    // Steps below one cycle are raised to exactly one cycle.
    always_comb begin
        w_step = amd_pkg::PHASE_W'(r_cycles_per_sample);
        if (w_step < amd_pkg::PHASE_ONE) begin
            w_step = amd_pkg::PHASE_ONE;
        end
        n_phase = r_phase;
        if (w_accept) begin
            if (w_emit) begin
                n_phase = r_phase + w_step - amd_pkg::PHASE_ONE;
            end else begin
                n_phase = r_phase - amd_pkg::PHASE_ONE;
            end
        end
    end

    // Emitting cycles go into the queue with their levels.
    always_comb begin
        o_push.valid            = w_accept && w_emit;
        o_push.levels.pulse_one = i_pulse_one_level;
        o_push.levels.pulse_two = i_pulse_two_level;
        o_push.levels.triangle  = i_triangle_level;
        o_push.levels.noise     = i_noise_level;
        o_push.levels.delta     = i_delta_level;
    end

    // Step register and phase accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles_per_sample <= amd_pkg::STEP_RESET;
            r_phase             <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cycles_per_sample <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
        end
    end

    // A non-emitting cycle moves the sample instant exactly one cycle closer.
    a_phase_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_emit) |=> (r_phase == $past(r_phase) - amd_pkg::PHASE_ONE))
        else $error("phase did not count down by one cycle");

endmodule

// ===== hw/rtl/amd_queue.sv =====
// Short queue that decouples the front from the mixing back end.
module amd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  amd_pkg::t_queue_item i_push,
    output logic                 o_full,
    output amd_pkg::t_queue_item o_head,
    input  logic                 i_pop
);

    amd_pkg::t_levels                r_mem [amd_pkg::QUEUE_DEPTH];
    logic [amd_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [amd_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [amd_pkg::QUEUE_AW:0]      r_count;
    logic [amd_pkg::QUEUE_AW:0]      n_count;

    assign o_full = r_count == (amd_pkg::QUEUE_AW+1)'(amd_pkg::QUEUE_DEPTH);

    // Head of the queue is shown to the back end.
    always_comb begin
        o_head.valid  = r_count != '0;
        o_head.levels = r_mem[r_rd_ptr];
    end

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.levels;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_count < (amd_pkg::QUEUE_AW+1)'(amd_pkg::QUEUE_DEPTH)))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/amd_mix.sv =====
// Back end: two-stage mixer that turns channel levels into a PCM sample.
module amd_mix (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  amd_pkg::t_queue_item               i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [amd_pkg::PCM_W-1:0]   o_pcm_sample
);

    logic                              r_s1_valid;
    logic [amd_pkg::SUM_W-1:0]         r_s1_sum;
    logic                              r_s2_valid;
    logic signed [amd_pkg::PCM_W-1:0]  r_s2_sample;
    logic                              w_s1_en;
    logic                              w_s2_en;
    logic [amd_pkg::SUM_W-1:0]         n_sum;
    logic [amd_pkg::ACC_W-1:0]         w_acc;
    logic signed [amd_pkg::ACC_W-1:0]  w_biased;
    logic signed [amd_pkg::ACC_W-1:0]  w_shifted;
    logic signed [amd_pkg::PCM_W-1:0]  n_s2_sample;

    // Stages advance when the stage ahead is free or its transfer completes.
    assign w_s2_en = !r_s2_valid || i_ready;
    assign w_s1_en = !r_s1_valid || w_s2_en;
    assign o_pop   = i_head.valid && w_s1_en;

    // Stage one: weighted sum of the levels with constant coefficients.
    always_comb begin
        n_sum = amd_pkg::K_PULSE
                  * (amd_pkg::SUM_W'(i_head.levels.pulse_one)
                     + amd_pkg::SUM_W'(i_head.levels.pulse_two))
              + amd_pkg::K_TRIANGLE * amd_pkg::SUM_W'(i_head.levels.triangle)
              + amd_pkg::K_NOISE    * amd_pkg::SUM_W'(i_head.levels.noise)
              + amd_pkg::K_DELTA    * amd_pkg::SUM_W'(i_head.levels.delta);
    end

    // Stage two: remove the offset and drop the Q8 fraction toward zero.
    always_comb begin
        w_acc = amd_pkg::ACC_W'(r_s1_sum) - amd_pkg::K_OFFSET;
        if (w_acc[amd_pkg::ACC_W-1]) begin
            w_biased = $signed(w_acc + amd_pkg::TRUNC_BIAS);
        end else begin
            w_biased = $signed(w_acc);
        end
        w_shifted   = w_biased >>> 8;
        n_s2_sample = w_shifted[amd_pkg::PCM_W-1:0];
    end

    // Pipeline registers; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= i_head.valid;
            end
            if (w_s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1_sum <= n_sum;
        end
        if (w_s2_en) begin
            r_s2_sample <= n_s2_sample;
        end
    end

    assign o_valid      = r_s2_valid;
    assign o_pcm_sample = r_s2_sample;

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_sample >= amd_pkg::PCM_MIN && r_s2_sample <= amd_pkg::PCM_MAX))
        else $error("mixed sample outside the reachable range");

endmodule

// ===== hw/rtl/apu_mixer_decimator_unit.sv =====
// A sample taken with the cycle that emits it is written into a queue entry and then passes
// the two mixer stages, stage one and then stage two, before it is offered at the output.
// Throughput: one sound-chip cycle per clock; a four-entry queue absorbs output stalls.
// Input stalls only when the queue is full.
// Reset (synchronous, active low) clears the phase, the queue and the pipeline valids,
// and loads the step register with 2659740, so the first cycle after reset emits.
module apu_mixer_decimator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [amd_pkg::LEVEL_W-1:0]        i_pulse_one_level,
    input  logic [amd_pkg::LEVEL_W-1:0]        i_pulse_two_level,
    input  logic [amd_pkg::LEVEL_W-1:0]        i_triangle_level,
    input  logic [amd_pkg::LEVEL_W-1:0]        i_noise_level,
    input  logic [amd_pkg::DELTA_W-1:0]        i_delta_level,
    input  logic                               i_cfg_wr_en,
    input  logic [amd_pkg::STEP_W-1:0]         i_cfg_wr_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [amd_pkg::PCM_W-1:0]   o_pcm_sample
);

    amd_pkg::t_queue_item w_push;
    amd_pkg::t_queue_item w_head;
    logic                 w_full;
    logic                 w_pop;

    // Front: phase accumulator and cycle selection.
    amd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pulse_one_level (i_pulse_one_level),
        .i_pulse_two_level (i_pulse_two_level),
        .i_triangle_level  (i_triangle_level),
        .i_noise_level     (i_noise_level),
        .i_delta_level     (i_delta_level),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_queue_full      (w_full),
        .o_push            (w_push)
    );

    // Queue of selected cycles.
    amd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Back: mixer pipeline and output register.
    amd_mix u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pcm_sample (o_pcm_sample)
    );

endmodule
